FILE: rtl/aruo_pkg.sv
// Package: constants, register indexes and op codes of the audio ring.
`default_nettype none
package aruo_pkg;

  localparam int RING_DEPTH  = 4096;
  localparam int PACKET_SIZE = 64;

  localparam int RING_AW  = $clog2(RING_DEPTH);
  localparam int FILL_W   = RING_AW + 1;
  localparam int PKT_W    = $clog2(PACKET_SIZE);
  localparam int SAMPLE_W = 32;
  localparam int COUNT_W  = 7;
  localparam int SHIFT_W  = 5;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [1:0] OP_WRITE       = 2'd0;
  localparam logic [1:0] OP_READ_SCALED = 2'd1;
  localparam logic [1:0] OP_READ_RAW    = 2'd2;

  localparam logic REG_VOLUME_SHIFT = 1'b0;
  localparam logic REG_REFILL_LEVEL = 1'b1;

  localparam logic [SHIFT_W-1:0] VOLUME_SHIFT_RST = SHIFT_W'(16);
  localparam logic [FILL_W-1:0]  REFILL_LEVEL_RST = FILL_W'(2880);

endpackage
`default_nettype wire

FILE: rtl/aruo_if.sv
// Interfaces: input item channel and result channel of the audio ring.
`default_nettype none
interface aruo_in_if;
  logic                                       valid;
  logic                                       ready;
  logic [1:0]                                 op;
  logic signed [aruo_pkg::SAMPLE_W-1:0]       sample_value;
  logic                                       batch_first;
  logic [aruo_pkg::COUNT_W-1:0]               batch_count;

  modport source (output valid, op, sample_value, batch_first, batch_count, input ready);
  modport sink   (input valid, op, sample_value, batch_first, batch_count, output ready);
endinterface

interface aruo_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [aruo_pkg::SAMPLE_W-1:0]       out_sample;
  logic                                       is_silence;
  logic                                       underrun;
  logic [aruo_pkg::FILL_W-1:0]                fill_count;
  logic                                       last;

  modport source (output valid, out_sample, is_silence, underrun, fill_count, last,
                  input ready);
  modport sink   (input valid, out_sample, is_silence, underrun, fill_count, last,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/audio_ring_under_overrun.sv
// Audio ring buffer with overrun discard and underrun freeze, top level.
//
// Usage:
//   in_ch carries write items (op 0, one sample each, batch_first and
//   batch_count on the first item of a batch) and packet reads (op 1
//   scaled to 16 bits by volume_shift, op 2 raw). op 3 is dropped.
//   out_ch delivers PACKET_SIZE results per read, last on the final one.
//   Registers volume_shift (0x0) and refill_level (0x4) sit on the APB
//   port; pready is always high.
// Timing:
//   A write is accepted, then written to the ring memory in ST_WRITE.
//   A read is accepted, then each sample passes memory read, output
//   register load and a transfer that waits for out_ch.ready; the single
//   ring memory port and one output register serve one sample at a time.
//   in_ch.ready is high only while no item is in work.
// Reset (rst_n low, synchronous): ring empty, freeze cleared, registers
//   at reset values. Ring contents are not cleared; no clearing pass.
// Stall: a result holds in the output register until out_ch.ready.
`default_nettype none
module audio_ring_under_overrun (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  aruo_in_if.sink                             in_ch,
  aruo_out_if.source                          out_ch,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [aruo_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [aruo_pkg::PDATA_W-1:0]   pwdata,
  output logic      [aruo_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready
);
  import aruo_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RD_REQ,
    ST_RD_LOAD,
    ST_RD_WAIT
  } state_t;

  state_t                     state_r;
  logic [RING_AW-1:0]         read_pos_r;
  logic [RING_AW-1:0]         write_pos_r;
  logic [FILL_W-1:0]          held_count_r;
  logic                       freeze_r;
  logic [SHIFT_W-1:0]         volume_shift_r;
  logic [FILL_W-1:0]          refill_level_r;
  logic [PKT_W-1:0]           slot_r;
  logic [PKT_W:0]             real_r;
  logic                       raw_r;
  logic                       underrun_r;
  logic [SAMPLE_W-1:0]        sample_r;
  logic [SAMPLE_W-1:0]        rdata_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       is_silence_r;
  logic                       last_r;

  logic [SAMPLE_W-1:0]        ring_mem [RING_DEPTH];

  // Configuration port
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    if (paddr[2] == REG_VOLUME_SHIFT) begin
      prdata = PDATA_W'(volume_shift_r);
    end else begin
      prdata = PDATA_W'(refill_level_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_shift_r <= VOLUME_SHIFT_RST;
      refill_level_r <= REFILL_LEVEL_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_VOLUME_SHIFT) begin
        volume_shift_r <= pwdata[SHIFT_W-1:0];
      end else begin
        refill_level_r <= pwdata[FILL_W-1:0];
      end
    end
  end

  // Overrun discard amount
  logic [FILL_W-1:0] space;
  logic [FILL_W-1:0] count_ext;
  logic [FILL_W:0]   half;
  logic [FILL_W:0]   drop_up;
  logic [FILL_W:0]   drop_cap;
  logic [FILL_W-1:0] drop;
  logic              overrun;

  assign space     = FILL_W'(RING_DEPTH) - held_count_r;
  assign count_ext = FILL_W'(in_ch.batch_count);
  assign half      = (($bits(half))'(RING_DEPTH) + ($bits(half))'(in_ch.batch_count)) >> 1;
  assign drop_up   = ((half + ($bits(half))'(PACKET_SIZE - 1)) >> PKT_W) << PKT_W;
  assign drop_cap  = (drop_up > ($bits(half))'(RING_DEPTH - PACKET_SIZE)) ?
                     ($bits(half))'(RING_DEPTH - PACKET_SIZE) : drop_up;
  assign drop      = (drop_cap > ($bits(half))'(held_count_r)) ? held_count_r :
                     drop_cap[FILL_W-1:0];
  assign overrun   = in_ch.batch_first && (space < count_ext);

  // Packet plan
  logic              short_fill;
  logic [PKT_W:0]    real_nxt;
  logic              under_nxt;
  logic              freeze_nxt;

  assign short_fill = held_count_r < FILL_W'(PACKET_SIZE);

  always_comb begin
    real_nxt   = (PKT_W+1)'(PACKET_SIZE);
    under_nxt  = 1'b0;
    freeze_nxt = freeze_r;
    priority if (short_fill) begin
      real_nxt   = held_count_r[PKT_W:0];
      under_nxt  = 1'b1;
      freeze_nxt = 1'b1;
    end else if (freeze_r) begin
      if (held_count_r < refill_level_r) begin
        real_nxt  = '0;
        under_nxt = 1'b1;
      end else begin
        freeze_nxt = 1'b0;
      end
    end
  end

  logic slot_real;
  logic slot_last;
  logic signed [SAMPLE_W-1:0] shifted;
  logic signed [SAMPLE_W-1:0] scaled;

  assign slot_real = {1'b0, slot_r} < real_r;
  assign slot_last = slot_r == PKT_W'(PACKET_SIZE - 1);
  assign shifted   = signed'(rdata_r) >>> volume_shift_r;
  assign scaled    = SAMPLE_W'(signed'(shifted[15:0]));

  // Ring memory
  logic mem_we;
  logic mem_re;
  assign mem_we = state_r == ST_WRITE;
  assign mem_re = (state_r == ST_RD_REQ) && slot_real;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[write_pos_r] <= sample_r;
    end
    if (mem_re) begin
      rdata_r <= ring_mem[read_pos_r];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      read_pos_r   <= '0;
      write_pos_r  <= '0;
      held_count_r <= '0;
      freeze_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      slot_r       <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            sample_r <= in_ch.sample_value;
            if (in_ch.op == OP_WRITE) begin
              if (overrun) begin
                held_count_r <= held_count_r - drop;
                read_pos_r   <= read_pos_r + drop[RING_AW-1:0];
              end
              state_r <= ST_WRITE;
            end else if (in_ch.op == OP_READ_SCALED || in_ch.op == OP_READ_RAW) begin
              raw_r        <= in_ch.op == OP_READ_RAW;
              real_r       <= real_nxt;
              underrun_r   <= under_nxt;
              freeze_r     <= freeze_nxt;
              held_count_r <= held_count_r - FILL_W'(real_nxt);
              slot_r       <= '0;
              state_r      <= ST_RD_REQ;
            end
          end
        end
        ST_WRITE: begin
          write_pos_r <= write_pos_r + 1'b1;
          if (held_count_r >= FILL_W'(RING_DEPTH)) begin
            read_pos_r <= read_pos_r + 1'b1;
          end else begin
            held_count_r <= held_count_r + 1'b1;
          end
          state_r <= ST_IDLE;
        end
        ST_RD_REQ: begin
          if (slot_real) begin
            read_pos_r <= read_pos_r + 1'b1;
          end
          state_r <= ST_RD_LOAD;
        end
        ST_RD_LOAD: begin
          out_valid_r  <= 1'b1;
          is_silence_r <= !slot_real;
          last_r       <= slot_last;
          if (!slot_real) begin
            out_sample_r <= '0;
          end else if (raw_r) begin
            out_sample_r <= signed'(rdata_r);
          end else begin
            out_sample_r <= scaled;
          end
          state_r <= ST_RD_WAIT;
        end
        ST_RD_WAIT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            slot_r      <= slot_r + 1'b1;
            state_r     <= slot_last ? ST_IDLE : ST_RD_REQ;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = state_r == ST_IDLE;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_sample = out_sample_r;
  assign out_ch.is_silence = is_silence_r;
  assign out_ch.underrun   = underrun_r;
  assign out_ch.fill_count = held_count_r;
  assign out_ch.last       = last_r;

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result is pending");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r <= FILL_W'(RING_DEPTH))
    else $error("fill count above ring depth");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last |=> in_ch.ready)
    else $error("sequencer not idle after last transfer");

  a_silence_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_silence |-> out_ch.out_sample == '0)
    else $error("silence with nonzero sample");

  a_fill_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last && out_ch.ready |=> $stable(out_ch.fill_count))
    else $error("fill count changed inside a packet");

endmodule
`default_nettype wire
